### hdl/block_bitmap_allocator_unit_macros.svh
// assertion helpers used by the allocator controller (bba_ctrl)
`ifndef BLOCK_BITMAP_ALLOCATOR_UNIT_MACROS_SVH
`define BLOCK_BITMAP_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/bba_pkg.sv
`default_nettype none

package bba_pkg;

    localparam int BLOCK_W   = 15;
    localparam int CFG_W     = 4;
    localparam int DIRTY_W   = 3;
    localparam int OP_W      = 2;
    localparam int WORD_BITS = 64;
    localparam int BIT_IDX_W = 6;

    localparam int MAX_MAP_SECTORS_DEF = 8;
    localparam int SECTOR_BYTES_DEF    = 512;
    localparam int MAP_WORDS_DEF       = MAX_MAP_SECTORS_DEF * SECTOR_BYTES_DEF / 8;
    localparam int CFG_RESET           = 8;

    localparam logic [OP_W-1:0] OP_TEST    = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND    = 2'd1;
    localparam logic [OP_W-1:0] OP_MARK    = 2'd2;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [BLOCK_W-1:0] block;
    } bba_in_t;

    typedef struct packed {
        logic               is_free;
        logic               found;
        logic [BLOCK_W-1:0] found_block;
        logic [DIRTY_W-1:0] dirty_sector;
        logic               out_of_range;
    } bba_out_t;

    typedef struct packed {
        logic clr_en;
        logic load;
        logic rd;
        logic exec;
        logic scan_start;
        logic scan;
        logic out_load;
    } bba_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic is_find;
        logic hit;
        logic miss;
    } bba_sts_t;

endpackage

`default_nettype wire

### hdl/bba_ram.sv
`default_nettype none

module bba_ram
    import bba_pkg::*;
#(
    parameter int WIDTH = WORD_BITS,
    parameter int DEPTH = MAP_WORDS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hdl/bba_ctrl.sv
`default_nettype none
`include "block_bitmap_allocator_unit_macros.svh"

module bba_ctrl
    import bba_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  wire logic     m_ready,
    input  wire bba_sts_t sts,
    output bba_cmd_t      cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD: begin
                if (sts.is_find) begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end else begin
                    cmd.rd     = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_DONE;
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.hit || sts.miss) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // result register waits for the output slot to free up
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `BBA_ASSERT_NEXT(a_one_word_in_flight, s_valid && s_ready, !s_ready, "second word accepted while busy")
    `BBA_ASSERT_NEXT(a_scan_hit_ends, (state_reg == S_SCAN) && sts.hit, state_reg == S_DONE, "scan did not stop on hit")
    `BBA_ASSERT_NOW(a_result_from_done, $rose(m_valid_reg), $past(state_reg) == S_DONE, "result word raised outside done")

endmodule

`default_nettype wire

### hdl/bba_dp.sv
`default_nettype none

module bba_dp
    import bba_pkg::*;
#(
    parameter int MAX_MAP_SECTORS = MAX_MAP_SECTORS_DEF,
    parameter int SECTOR_BYTES    = SECTOR_BYTES_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire bba_in_t          s_data,
    output bba_out_t              m_data,
    input  wire bba_cmd_t         cmd,
    output bba_sts_t              sts
);

    localparam int MAP_WORDS        = MAX_MAP_SECTORS * SECTOR_BYTES / 8;
    localparam int WORDS_PER_SECTOR = SECTOR_BYTES / 8;
    localparam int FIELD_WORDS      = (2 ** BLOCK_W) / WORD_BITS;
    localparam int ADDR_W           = $clog2(MAP_WORDS);
    localparam int CNT_W            = ADDR_W + 1;
    localparam int SEC_W            = $clog2(MAX_MAP_SECTORS + 1);
    localparam int BYTE_W           = BLOCK_W - 3;
    localparam int BWORD_W          = BLOCK_W - BIT_IDX_W;

    // searchable words: live map capped to what the block field can name
    function automatic logic [CNT_W-1:0] span_of(input logic [CFG_W-1:0] c);
        int s;
        int w;
        s = int'(c);
        if (s > MAX_MAP_SECTORS) begin
            s = MAX_MAP_SECTORS;
        end
        w = s * WORDS_PER_SECTOR;
        if (w > FIELD_WORDS) begin
            w = FIELD_WORDS;
        end
        return CNT_W'(w);
    endfunction

    logic [CNT_W-1:0]     span_reg;
    bba_in_t              item_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 chk_valid_reg;
    logic [ADDR_W-1:0]    chk_addr_reg;
    bba_out_t             result_reg;
    bba_out_t             result_next;
    bba_out_t             m_data_reg;

    logic [BWORD_W-1:0]   blk_word;
    logic [ADDR_W-1:0]    blk_addr;
    logic [BYTE_W-1:0]    byte_idx;
    logic [WORD_BITS-1:0] bit_mask;
    logic                 in_range;
    logic                 issue;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] free_bits;
    logic [BIT_IDX_W-1:0] hit_idx;
    logic [SEC_W-1:0]     sec_idx;
    logic                 is_update;

    assign cfg_ready = 1'b1;

    assign blk_word  = item_reg.block[BLOCK_W-1:BIT_IDX_W];
    assign blk_addr  = ADDR_W'(blk_word);
    assign byte_idx  = item_reg.block[BLOCK_W-1:3];
    assign bit_mask  = WORD_BITS'(1) << item_reg.block[BIT_IDX_W-1:0];
    assign in_range  = 32'(blk_word) < 32'(span_reg);
    assign issue     = cmd.scan && (cnt_reg < span_reg);
    assign is_update = (item_reg.op == OP_MARK) || (item_reg.op == OP_RELEASE);

    assign ram_re    = cmd.rd || issue;
    assign ram_raddr = cmd.rd ? blk_addr : cnt_reg[ADDR_W-1:0];
    assign ram_we    = cmd.clr_en || (cmd.exec && in_range && is_update);
    assign ram_waddr = cmd.clr_en ? cnt_reg[ADDR_W-1:0] : blk_addr;

    always_comb begin
        if (cmd.clr_en) begin
            ram_wdata = '0;
        end else if (item_reg.op == OP_MARK) begin
            ram_wdata = ram_rdata | bit_mask;
        end else begin
            ram_wdata = ram_rdata & ~bit_mask;
        end
    end

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // block 0 never comes back from a search
    always_comb begin
        free_bits = ~ram_rdata;
        if (chk_addr_reg == '0) begin
            free_bits[0] = 1'b0;
        end
        hit_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                hit_idx = BIT_IDX_W'(i);
            end
        end
    end

    // map sector of the block, one threshold per sector boundary
    always_comb begin
        sec_idx = '0;
        for (int k = 1; k < MAX_MAP_SECTORS; k++) begin
            if (32'(byte_idx) >= k * SECTOR_BYTES) begin
                sec_idx = sec_idx + SEC_W'(1);
            end
        end
    end

    assign sts.clr_last = cnt_reg[ADDR_W-1:0] == ADDR_W'(MAP_WORDS - 1);
    assign sts.is_find  = item_reg.op == OP_FIND;
    assign sts.hit      = chk_valid_reg && (|free_bits);
    assign sts.miss     = !chk_valid_reg && (cnt_reg >= span_reg);

    always_comb begin
        result_next = result_reg;
        if (cmd.exec) begin
            result_next = '0;
            if (!in_range) begin
                result_next.out_of_range = 1'b1;
            end else begin
                case (item_reg.op) inside
                    OP_TEST: begin
                        result_next.is_free = ~|(ram_rdata & bit_mask);
                    end
                    OP_MARK, OP_RELEASE: begin
                        result_next.dirty_sector = DIRTY_W'(sec_idx);
                    end
                    default: begin
                    end
                endcase
            end
        end else if (cmd.scan && sts.hit) begin
            result_next             = '0;
            result_next.found       = 1'b1;
            result_next.found_block = BLOCK_W'({chk_addr_reg, hit_idx});
        end else if (cmd.scan && sts.miss) begin
            result_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            span_reg      <= span_of(CFG_W'(CFG_RESET));
            cnt_reg       <= '0;
            chk_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                span_reg <= span_of(cfg_data);
            end
            if (cmd.scan_start) begin
                cnt_reg       <= '0;
                chk_valid_reg <= 1'b0;
            end else begin
                if (cmd.clr_en || issue) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                if (cmd.scan) begin
                    chk_valid_reg <= issue;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
        end
        if (issue) begin
            chk_addr_reg <= cnt_reg[ADDR_W-1:0];
        end
        result_reg <= result_next;
        if (cmd.out_load) begin
            m_data_reg <= result_reg;
        end
    end

    assign m_data = m_data_reg;

endmodule

`default_nettype wire

### hdl/block_bitmap_allocator_unit.sv
// Block occupancy bitmap allocator: one bit per disk block (1 = used) held in a
// 64-bit-wide RAM of MAX_MAP_SECTORS*SECTOR_BYTES/8 words (512 at defaults).
// After reset the unit sweeps the RAM to zero, one word per cycle; s_ready
// stays low until the sweep ends, while cfg writes are taken at any time
// (cfg_ready is always high). Test, mark and release go through one RAM read
// and one read-modify-write step before the result word is loaded. Find reads
// one 64-bit word per cycle through the single RAM read port, up to the number
// of searchable live words. One request is worked at a time; the finished
// result sits in an output register, so the next request is accepted while
// that result waits for m_ready.
`default_nettype none

module block_bitmap_allocator_unit
    import bba_pkg::*;
#(
    parameter int MAX_MAP_SECTORS = MAX_MAP_SECTORS_DEF,
    parameter int SECTOR_BYTES    = SECTOR_BYTES_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire bba_in_t          s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output bba_out_t              m_data
);

    bba_cmd_t cmd;
    bba_sts_t sts;

    bba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bba_dp #(
        .MAX_MAP_SECTORS (MAX_MAP_SECTORS),
        .SECTOR_BYTES    (SECTOR_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire
